// ----- hdl/arcade_io_ports_with_shift_register_assert.svh -----
// assertion macros used by the i/o board rtl
`ifndef ARCADE_IO_PORTS_WITH_SHIFT_REGISTER_ASSERT_SVH
`define ARCADE_IO_PORTS_WITH_SHIFT_REGISTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition implies consequence in the same cycle
`define AIOSR_ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// condition implies consequence in the next cycle
`define AIOSR_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define AIOSR_ASSERT_SAME(label, clk, rst, cond, cons)
`define AIOSR_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif
`endif

// ----- hdl/aiosr_pkg.sv -----
// types and codes of the arcade i/o board
package aiosr_pkg;

  // bus event codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_COIN  = 2'd2;

  // port numbers
  localparam logic [2:0] PORT_INPUTS_ONE   = 3'd1;
  localparam logic [2:0] PORT_INPUTS_TWO   = 3'd2;
  localparam logic [2:0] PORT_SHIFT_OFFSET = 3'd2;
  localparam logic [2:0] PORT_SHIFT_RESULT = 3'd3;
  localparam logic [2:0] PORT_SOUND_A      = 3'd3;
  localparam logic [2:0] PORT_SHIFT_DATA   = 3'd4;
  localparam logic [2:0] PORT_SOUND_B      = 3'd5;

  localparam int OFFSET_W = 3;
  localparam int SOUND_W  = 6;

  // one bus event as held in the input register
  typedef struct packed {
    logic [1:0] action;
    logic [2:0] port;
    logic [7:0] write_data;
    logic       start_one;
    logic       start_two;
    logic       fire_button;
    logic       left_button;
    logic       right_button;
    logic       extra_high_button;
    logic       extra_mid_button;
  } cmd_t;

  // controls from the port decoder to the shift unit
  typedef struct packed {
    logic load_offset;
    logic push_byte;
  } shift_ctl_t;

endpackage

// ----- hdl/aiosr_if.sv -----
// handshake channels of the arcade i/o board

// bus event channel
interface aiosr_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] port;
  logic [7:0] write_data;
  logic       start_one;
  logic       start_two;
  logic       fire_button;
  logic       left_button;
  logic       right_button;
  logic       extra_high_button;
  logic       extra_mid_button;

  modport source (
    output valid, action, port, write_data, start_one, start_two, fire_button,
           left_button, right_button, extra_high_button, extra_mid_button,
    input  ready
  );
  modport sink (
    input  valid, action, port, write_data, start_one, start_two, fire_button,
           left_button, right_button, extra_high_button, extra_mid_button,
    output ready
  );
endinterface

// result channel
interface aiosr_rsp_if;
  import aiosr_pkg::*;
  logic               valid;
  logic               ready;
  logic [7:0]         read_data;
  logic [SOUND_W-1:0] sound_start;

  modport source (output valid, read_data, sound_start, input ready);
  modport sink (input valid, read_data, sound_start, output ready);
endinterface

// ----- hdl/arcade_io_ports_with_shift_register.sv -----
// I/O board of an 8080 arcade machine: takes one bus event (port read, port
// write or coin insertion) per clock unless stalled and returns one result
// per event. An event is captured in an input register, decoded against the
// board state (shift register, shift offset, last sound bytes, coin latch) as
// it moves to the result register, and a new event can be taken every cycle
// while the result side accepts. The only stall comes from the result side:
// while a finished result waits, the input register still takes one more
// event before ready drops.
module arcade_io_ports_with_shift_register (
  input logic        clk,
  input logic        rst,
  aiosr_cmd_if.sink  cmd,
  aiosr_rsp_if.source rsp
);
  import aiosr_pkg::*;
  `include "arcade_io_ports_with_shift_register_assert.svh"

  logic               s1_valid;
  cmd_t               s1;
  logic               s1_adv;
  logic               out_ready;
  logic               out_valid;
  logic [7:0]         read_data;
  logic [SOUND_W-1:0] sound_start;
  logic [7:0]         read_data_next;
  logic [SOUND_W-1:0] sound_start_next;
  logic [7:0]         last_sound_byte_a;
  logic [7:0]         last_sound_byte_b;
  logic               coin_latch;
  logic [7:0]         rise;
  logic [7:0]         window;
  shift_ctl_t         shift_ctl;

  // handshake flow
  assign out_ready = !out_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_ready;
  assign cmd.ready = !s1_valid || out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1.action            <= cmd.action;
      s1.port              <= cmd.port;
      s1.write_data        <= cmd.write_data;
      s1.start_one         <= cmd.start_one;
      s1.start_two         <= cmd.start_two;
      s1.fire_button       <= cmd.fire_button;
      s1.left_button       <= cmd.left_button;
      s1.right_button      <= cmd.right_button;
      s1.extra_high_button <= cmd.extra_high_button;
      s1.extra_mid_button  <= cmd.extra_mid_button;
    end
  end

  // shift register controls
  assign shift_ctl.load_offset = s1_adv && s1.action == ACT_WRITE
                                 && s1.port == PORT_SHIFT_OFFSET;
  assign shift_ctl.push_byte   = s1_adv && s1.action == ACT_WRITE
                                 && s1.port == PORT_SHIFT_DATA;

  aiosr_shifter u_shifter (
    .clk    (clk),
    .rst    (rst),
    .ctl    (shift_ctl),
    .data   (s1.write_data),
    .window (window)
  );

  // rising bits of the sound byte being written
  always_comb begin
    if (s1.port == PORT_SOUND_A) begin
      rise = s1.write_data & ~last_sound_byte_a;
    end else begin
      rise = s1.write_data & ~last_sound_byte_b;
    end
  end

  // result decode
  always_comb begin
    read_data_next   = '0;
    sound_start_next = '0;
    case (s1.action)
      ACT_READ: begin
        case (s1.port)
          PORT_INPUTS_ONE: read_data_next = {s1.extra_high_button, s1.right_button,
                                             s1.left_button, s1.fire_button,
                                             s1.extra_mid_button, s1.start_one,
                                             s1.start_two, coin_latch};
          PORT_INPUTS_TWO: read_data_next = {1'b0, s1.right_button, s1.left_button,
                                             s1.fire_button, 4'b0000};
          PORT_SHIFT_RESULT: read_data_next = window;
          default: read_data_next = '0;
        endcase
      end
      ACT_WRITE: begin
        case (s1.port)
          PORT_SOUND_A: sound_start_next = {2'b00, rise[2], rise[0], rise[3], rise[1]};
          PORT_SOUND_B: sound_start_next = {rise[0], rise[1], 4'b0000};
          default: sound_start_next = '0;
        endcase
      end
      default: begin
        read_data_next   = '0;
        sound_start_next = '0;
      end
    endcase
  end

  // board state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sound_byte_a <= '0;
      last_sound_byte_b <= '0;
      coin_latch        <= 1'b0;
    end else if (s1_adv) begin
      if (s1.action == ACT_COIN) begin
        coin_latch <= 1'b1;
      end else if (s1.action == ACT_READ && s1.port == PORT_INPUTS_ONE) begin
        coin_latch <= 1'b0;
      end
      if (s1.action == ACT_WRITE && s1.port == PORT_SOUND_A) begin
        last_sound_byte_a <= s1.write_data;
      end
      if (s1.action == ACT_WRITE && s1.port == PORT_SOUND_B) begin
        last_sound_byte_b <= s1.write_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data   <= read_data_next;
      sound_start <= sound_start_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_data   = read_data;
  assign rsp.sound_start = sound_start;

  // checks
  `AIOSR_ASSERT_SAME(a_one_kind_of_result, clk, rst, rsp.valid, rsp.read_data == '0 || rsp.sound_start == '0)
  `AIOSR_ASSERT_SAME(a_stall_needs_held_item, clk, rst, !cmd.ready, s1_valid && out_valid)
  `AIOSR_ASSERT_NEXT(a_advance_gives_result, clk, rst, s1_adv, out_valid)
  `AIOSR_ASSERT_NEXT(a_coin_read_clears, clk, rst, s1_adv && s1.action == ACT_READ && s1.port == PORT_INPUTS_ONE, !coin_latch)

endmodule

// ----- hdl/aiosr_shifter.sv -----
// 16-bit shift register with offset and byte window read
module aiosr_shifter (
  input  logic                   clk,
  input  logic                   rst,
  input  aiosr_pkg::shift_ctl_t  ctl,
  input  logic [7:0]             data,
  output logic [7:0]             window
);
  import aiosr_pkg::*;

  logic [15:0]         shift_data;
  logic [OFFSET_W-1:0] shift_offset;
  logic [15:0]         shifted;

  // new byte enters the top, old top byte drops to the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_data   <= '0;
      shift_offset <= '0;
    end else begin
      if (ctl.push_byte) begin
        shift_data <= {data, shift_data[15:8]};
      end
      if (ctl.load_offset) begin
        shift_offset <= data[OFFSET_W-1:0];
      end
    end
  end

  // window is bits 15-offset down to 8-offset
  assign shifted = shift_data << shift_offset;
  assign window  = shifted[15:8];

endmodule
